/* rtl/nns_pkg.sv */
// Shared constants and types for the nearest neighbor search block.
package nns_pkg;

  localparam int MAX_DIMENSIONS_DEF = 4;
  localparam int MAX_POINTS_DEF     = 1024;
  localparam int COORD_WIDTH_DEF    = 16;

  localparam int NUM_COORD   = 4;
  localparam int POS_W       = 2;
  localparam int DIMS_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_DIMS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_X0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_X3 = 3'd4;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic              close;
    logic              last;
    logic [DIMS_W-1:0] nd;
  } nns_ctl_t;

endpackage

/* rtl/nns_front.sv */
// Front end: config registers, coordinate position tracking and query difference.
module nns_front #(
  parameter int MAX_DIMENSIONS = nns_pkg::MAX_DIMENSIONS_DEF,
  parameter int COORD_WIDTH    = nns_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [COORD_WIDTH-1:0]      coord,
  input  logic                               s_tlast,
  input  logic                               cfg_write,
  input  logic [nns_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               fifo_full,
  output logic                               push,
  output nns_pkg::nns_ctl_t                  push_ctl,
  output logic signed [COORD_WIDTH-1:0]      push_coord,
  output logic signed [COORD_WIDTH:0]        push_diff
);
  import nns_pkg::*;

  logic [DIMS_W-1:0]             dims;
  logic signed [COORD_WIDTH-1:0] query [NUM_COORD];
  logic [POS_W-1:0]              coord_count;
  logic [POS_W-1:0]              coord_count_next;
  logic [DIMS_W-1:0]             nd;
  logic [DIMS_W-1:0]             pos_inc;
  logic                          close;
  logic signed [COORD_WIDTH-1:0] q;

  always_comb begin
    if (dims == '0) begin
      nd = DIMS_W'(1);
    end else if (dims > DIMS_W'(MAX_DIMENSIONS)) begin
      nd = DIMS_W'(MAX_DIMENSIONS);
    end else begin
      nd = dims;
    end
  end

  assign s_tready = !fifo_full;
  assign push     = s_tvalid && s_tready;
  assign pos_inc  = DIMS_W'(coord_count) + DIMS_W'(1);
  assign close    = (pos_inc >= nd) || s_tlast;
  assign q        = query[coord_count];
  assign coord_count_next = close ? '0 : pos_inc[POS_W-1:0];

  assign push_ctl.pos   = coord_count;
  assign push_ctl.close = close;
  assign push_ctl.last  = s_tlast;
  assign push_ctl.nd    = nd;
  assign push_coord     = coord;
  assign push_diff      = {coord[COORD_WIDTH-1], coord} - {q[COORD_WIDTH-1], q};

  always_ff @(posedge clk) begin
    if (rst) begin
      dims        <= DIMS_RESET;
      coord_count <= '0;
      for (int k = 0; k < NUM_COORD; k++) begin
        query[k] <= '0;
      end
    end else begin
      if (push) begin
        coord_count <= coord_count_next;
      end
      if (cfg_write) begin
        if (cfg_index == REG_DIMS) begin
          dims <= cfg_data[DIMS_W-1:0];
        end
        for (int k = 0; k < NUM_COORD; k++) begin
          if (k < MAX_DIMENSIONS && cfg_index == CFG_INDEX_W'(int'(REG_QUERY_X0) + k)) begin
            query[k] <= COORD_WIDTH'(cfg_data);
          end
        end
      end
    end
  end

endmodule

/* rtl/nns_fifo.sv */
// Small register queue between the front end and the distance back end.
module nns_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nns_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("write into full queue");
  assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("read from empty queue");

endmodule

/* rtl/nns_back.sv */
// Back end: square, accumulate, best point tracking and result register.
module nns_back #(
  parameter int MAX_POINTS  = nns_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = nns_pkg::COORD_WIDTH_DEF,
  parameter int IDX_W       = $clog2(MAX_POINTS),
  parameter int DIST_W      = 2 * COORD_WIDTH + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          pop,
  input  nns_pkg::nns_ctl_t             q_ctl,
  input  logic signed [COORD_WIDTH-1:0] q_coord,
  input  logic signed [COORD_WIDTH:0]   q_diff,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [IDX_W-1:0]              best_index,
  output logic signed [COORD_WIDTH-1:0] best_c [nns_pkg::NUM_COORD],
  output logic [DIST_W-1:0]             best_sq_distance
);
  import nns_pkg::*;

  localparam int SQ_W  = 2 * COORD_WIDTH;
  localparam int ACC_W = 2 * COORD_WIDTH + 3;

  logic                          a_valid;
  nns_ctl_t                      a_ctl;
  logic signed [COORD_WIDTH-1:0] a_coord;
  logic [SQ_W-1:0]               a_sq;
  logic                          a_take;
  logic                          a_load;
  logic signed [SQ_W+1:0]        sq_full;

  logic [ACC_W-1:0]              running;
  logic [ACC_W-1:0]              min_dist;
  logic [IDX_W-1:0]              point_index;
  logic [IDX_W-1:0]              best_idx;
  logic signed [COORD_WIDTH-1:0] current_point [NUM_COORD];
  logic signed [COORD_WIDTH-1:0] best_point [NUM_COORD];

  logic [ACC_W-1:0]              acc_new;
  logic                          better;
  logic signed [COORD_WIDTH-1:0] cur_new [NUM_COORD];
  logic [ACC_W-1:0]              sel_dist;
  logic [IDX_W-1:0]              sel_idx;
  logic signed [COORD_WIDTH-1:0] sel_point [NUM_COORD];

  assign a_take  = a_valid && (!a_ctl.last || !m_tvalid || m_tready);
  assign a_load  = !a_valid || a_take;
  assign pop     = q_valid && a_load;
  assign sq_full = q_diff * q_diff;

  assign acc_new  = running + ACC_W'(a_sq);
  assign better   = acc_new < min_dist;
  assign sel_dist = better ? acc_new : min_dist;
  assign sel_idx  = better ? point_index : best_idx;

  always_comb begin
    for (int k = 0; k < NUM_COORD; k++) begin
      cur_new[k] = (a_ctl.pos == POS_W'(k)) ? a_coord : current_point[k];
      sel_point[k] = better ? cur_new[k] : best_point[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
      running     <= '0;
      min_dist    <= '1;
      point_index <= '0;
      best_idx    <= '0;
      for (int k = 0; k < NUM_COORD; k++) begin
        current_point[k] <= '0;
        best_point[k]    <= '0;
      end
    end else begin
      if (a_load) begin
        a_valid <= q_valid;
      end
      if (a_take && a_ctl.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (a_take) begin
        if (a_ctl.last) begin
          running     <= '0;
          min_dist    <= '1;
          point_index <= '0;
          best_idx    <= '0;
          for (int k = 0; k < NUM_COORD; k++) begin
            current_point[k] <= '0;
            best_point[k]    <= '0;
          end
        end else if (a_ctl.close) begin
          if (better) begin
            min_dist   <= acc_new;
            best_idx   <= point_index;
            best_point <= cur_new;
          end
          if (point_index != IDX_W'(MAX_POINTS - 1)) begin
            point_index <= point_index + IDX_W'(1);
          end
          running <= '0;
          for (int k = 0; k < NUM_COORD; k++) begin
            current_point[k] <= '0;
          end
        end else begin
          running       <= acc_new;
          current_point <= cur_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_ctl   <= q_ctl;
      a_coord <= q_coord;
      a_sq    <= sq_full[SQ_W-1:0];
    end
    if (a_take && a_ctl.last) begin
      best_index       <= sel_idx;
      best_sq_distance <= sel_dist[DIST_W-1:0];
      for (int k = 0; k < NUM_COORD; k++) begin
        best_c[k] <= (DIMS_W'(k) < a_ctl.nd) ? sel_point[k] : '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) a_take && a_ctl.last |=> m_tvalid)
    else $error("closed set gave no result");
  assert property (@(posedge clk) disable iff (rst)
    a_take && a_ctl.last |=> (point_index == '0 && running == '0 && min_dist == '1))
    else $error("set state not cleared after result");
  assert property (@(posedge clk) disable iff (rst) a_valid && a_ctl.last |-> a_ctl.close)
    else $error("last item did not close its point");

endmodule

/* rtl/nearest_neighbor_search.sv */
// Path: queue, back end input stage, result register (loaded by the tlast item).
// Throughput: one coordinate request per cycle unless the queue is full; a 4-entry
// queue decouples the front end from the square/accumulate back end, and a result
// register lets the next set proceed while a result waits.
// Reset: clears set state, dims returns to 2, query coordinates to zero.
// Top level: nearest point search by squared Euclidean distance.
module nearest_neighbor_search #(
  parameter int MAX_DIMENSIONS = nns_pkg::MAX_DIMENSIONS_DEF,
  parameter int MAX_POINTS     = nns_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH    = nns_pkg::COORD_WIDTH_DEF,
  parameter int IDX_W          = $clog2(MAX_POINTS),
  parameter int DIST_W         = 2 * COORD_WIDTH + 2,
  parameter int IN_TDATA_W     = ((COORD_WIDTH + 7) / 8) * 8,
  parameter int OUT_TDATA_W    =
    ((IDX_W + nns_pkg::NUM_COORD * COORD_WIDTH + DIST_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [IN_TDATA_W-1:0]           s_tdata,   // coord
  input  logic                            s_tlast,   // last_in_set
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // best_index, best_c0, best_c1, best_c2, best_c3, best_sq_distance
  output logic [OUT_TDATA_W-1:0]          m_tdata,
  input  logic                            cfg_write,
  input  logic [nns_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nns_pkg::*;

  localparam int CTL_W   = $bits(nns_ctl_t);
  localparam int ENTRY_W = CTL_W + COORD_WIDTH + COORD_WIDTH + 1;

  logic                          fifo_full;
  logic                          fifo_empty;
  logic                          push;
  logic                          pop;
  nns_ctl_t                      push_ctl;
  logic signed [COORD_WIDTH-1:0] push_coord;
  logic signed [COORD_WIDTH:0]   push_diff;
  logic [ENTRY_W-1:0]            wr_data;
  logic [ENTRY_W-1:0]            rd_data;
  nns_ctl_t                      q_ctl;
  logic signed [COORD_WIDTH-1:0] q_coord;
  logic signed [COORD_WIDTH:0]   q_diff;
  logic [IDX_W-1:0]              best_index;
  logic signed [COORD_WIDTH-1:0] best_c [NUM_COORD];
  logic [DIST_W-1:0]             best_sq_distance;

  nns_front #(
    .MAX_DIMENSIONS(MAX_DIMENSIONS),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .coord     (s_tdata[COORD_WIDTH-1:0]),
    .s_tlast   (s_tlast),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_coord(push_coord),
    .push_diff (push_diff)
  );

  assign wr_data = {push_ctl, push_coord, push_diff};

  nns_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(wr_data),
    .full   (fifo_full),
    .rd_en  (pop),
    .rd_data(rd_data),
    .empty  (fifo_empty)
  );

  assign {q_ctl, q_coord, q_diff} = rd_data;

  nns_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH),
    .IDX_W      (IDX_W),
    .DIST_W     (DIST_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (!fifo_empty),
    .pop             (pop),
    .q_ctl           (q_ctl),
    .q_coord         (q_coord),
    .q_diff          (q_diff),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .best_index      (best_index),
    .best_c          (best_c),
    .best_sq_distance(best_sq_distance)
  );

  assign m_tdata = OUT_TDATA_W'({best_sq_distance, best_c[3], best_c[2], best_c[1], best_c[0],
                                 best_index});

endmodule
